FILE: hdl/fbpa_pkg.sv
package fbpa_pkg;

	localparam int ACT_W   = 2;
	localparam int FIDX_W  = 10;
	localparam int ST_W    = 2;
	localparam int BIDX_W  = 10;
	localparam int OFS_W   = 24;

	localparam int POOL_W    = 24;
	localparam int BLK_W     = 16;
	localparam int ALN_W     = 17;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 1;

	localparam int DVD_W  = 24;
	localparam int DVS_W  = 17;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam int RST_POOL_BYTES  = 65536;
	localparam int RST_BLOCK_BYTES = 64;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;
	localparam logic [ST_W-1:0] ST_TOO_SMALL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_res_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [BIDX_W-1:0] block_index;
		logic [OFS_W-1:0]  byte_offset;
	} rsp_t;

endpackage

FILE: hdl/fbpa_req_if.sv
interface fbpa_req_if;
	import fbpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [FIDX_W-1:0] free_index;

	modport source (output valid, output action, output free_index, input ready);
	modport sink (input valid, input action, input free_index, output ready);

endinterface

FILE: hdl/fbpa_rsp_if.sv
interface fbpa_rsp_if;
	import fbpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [BIDX_W-1:0] block_index;
	logic [OFS_W-1:0]  byte_offset;

	modport source (output valid, output status, output block_index, output byte_offset,
		input ready);
	modport sink (input valid, input status, input block_index, input byte_offset,
		output ready);

endinterface

FILE: hdl/fbpa_div.sv
module fbpa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fbpa_pkg::div_cmd_t   cmd,
	output fbpa_pkg::div_res_t   res
);
	import fbpa_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= cmd.dividend;
				rem_q  <= '0;
				dvs_q  <= cmd.divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

FILE: hdl/fixed_block_pool_allocator.sv
// Channel  Role    Payload
// cfg_*    write   cfg_index, cfg_data (pool_bytes, block_bytes)
// req      sink    action, free_index
// rsp      source  status, block_index, byte_offset
//
// Allocate passes through S_ALLOC_RD: the head link is read from the registered link memory.
// Deallocate, error answers and unused codes are answered directly from S_IDLE.
// Rebuild runs one 24-step pass of the serial divider for the block count.
// Reset state equals a rebuild from the reset register values; no clearing pass.
// A result waiting in the output register holds off the next request until it is taken.
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS      = 1024,
	parameter int ALIGN_BYTES     = 16,
	parameter int MIN_BLOCK_BYTES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fbpa_pkg::CFG_W-1:0]       cfg_data,
	fbpa_req_if.sink                         req,
	fbpa_rsp_if.source                       rsp
);
	import fbpa_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
	localparam int PROD_W = IDX_W + ALN_W;

	localparam bit RST_ERR     = RST_BLOCK_BYTES <= MIN_BLOCK_BYTES;
	localparam int RST_ROUND   = ((RST_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES)
		* ALIGN_BYTES;
	localparam int RST_ALIGNED = RST_ERR ? RST_BLOCK_BYTES : RST_ROUND;
	localparam int RST_COUNT   = RST_POOL_BYTES / RST_ROUND;
	localparam int RST_TOTAL   = RST_ERR ? 0 :
		((RST_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RST_COUNT);
	localparam int RST_HEAD    = (RST_TOTAL == 0) ? MAX_BLOCKS : 0;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
	localparam logic [ALN_W-1:0]  ALN_MASK  = ALN_W'(ALIGN_BYTES - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_CNT_GO,
		S_CNT_WAIT
	} state_t;

	state_t              state_q;
	logic [POOL_W-1:0]   pool_bytes_q;
	logic [BLK_W-1:0]    block_bytes_q;
	logic [LINK_W-1:0]   head_q;
	logic [LINK_W-1:0]   fresh_q;
	logic [LINK_W-1:0]   total_q;
	logic [ALN_W-1:0]    aligned_q;
	logic                size_err_q;
	logic                fwd_q;
	logic [LINK_W-1:0]   fwd_data_q;
	logic                out_valid_q;
	rsp_t                rsp_q;

	logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
	logic [LINK_W-1:0]   link_rd_q;

	logic                acc;
	logic                head_null;
	logic                lazy;
	logic [LINK_W-1:0]   fresh_nxt;
	logic [LINK_W-1:0]   lazy_link;
	logic                idx_ok;
	logic                free_ok;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [LINK_W-1:0]   mem_wd;
	logic                too_small;
	logic [ALN_W-1:0]    aligned_nxt;
	logic [LINK_W-1:0]   count_sat;
	logic [PROD_W-1:0]   prod;
	div_cmd_t            div_cmd;
	div_res_t            div_res;

	fbpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;

	always_comb begin
		head_null = head_q >= NULL_LINK;
		fresh_nxt = fresh_q + 1'b1;
		lazy_link = (fresh_nxt < total_q) ? fresh_nxt : NULL_LINK;
		lazy      = acc && (req.action == ACT_ALLOC) && !size_err_q
			&& (fresh_q < total_q) && (32'(fresh_q) < 32'(MAX_BLOCKS));
		idx_ok    = (32'(req.free_index) < 32'(total_q))
			&& (32'(req.free_index) < 32'(MAX_BLOCKS));
		free_ok   = acc && (req.action == ACT_FREE) && !size_err_q && idx_ok;
		mem_we    = lazy || free_ok;
		mem_wa    = lazy ? fresh_q[IDX_W-1:0] : IDX_W'(req.free_index);
		mem_wd    = lazy ? lazy_link : head_q;
		too_small = 32'(block_bytes_q) <= 32'(MIN_BLOCK_BYTES);
		aligned_nxt = (ALN_W'(block_bytes_q) + ALN_MASK) & ~ALN_MASK;
		count_sat = (div_res.quotient > DVD_W'(MAX_BLOCKS)) ? NULL_LINK
			: LINK_W'(div_res.quotient);
		prod      = PROD_W'(head_q[IDX_W-1:0]) * PROD_W'(aligned_q);

		div_cmd.start    = (state_q == S_CNT_GO);
		div_cmd.dividend = pool_bytes_q;
		div_cmd.divisor  = aligned_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_bytes_q  <= POOL_W'(RST_POOL_BYTES);
			block_bytes_q <= BLK_W'(RST_BLOCK_BYTES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BYTES:  pool_bytes_q  <= cfg_data;
				REG_BLOCK_BYTES: block_bytes_q <= cfg_data[BLK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		link_rd_q <= link_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= LINK_W'(RST_HEAD);
			fresh_q     <= '0;
			total_q     <= LINK_W'(RST_TOTAL);
			aligned_q   <= ALN_W'(RST_ALIGNED);
			size_err_q  <= RST_ERR;
			fwd_q       <= 1'b0;
			fwd_data_q  <= '0;
			out_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.action)
							ACT_ALLOC: begin
								if (size_err_q) begin
									out_valid_q <= 1'b1;
									rsp_q       <= '{ST_TOO_SMALL, '0, '0};
								end else begin
									if (lazy) begin
										fresh_q <= fresh_nxt;
									end
									if (head_null) begin
										out_valid_q <= 1'b1;
										rsp_q       <= '{ST_EMPTY, '0, '0};
									end else begin
										fwd_q      <= lazy && (fresh_q == head_q);
										fwd_data_q <= lazy_link;
										state_q    <= S_ALLOC_RD;
									end
								end
							end
							ACT_FREE: begin
								out_valid_q <= 1'b1;
								if (size_err_q) begin
									rsp_q <= '{ST_TOO_SMALL, '0, '0};
								end else if (!idx_ok) begin
									rsp_q <= '{ST_BAD_INDEX, '0, '0};
								end else begin
									head_q <= LINK_W'(req.free_index);
									rsp_q  <= '{ST_OK, '0, '0};
								end
							end
							ACT_REBUILD: begin
								fresh_q <= '0;
								if (too_small) begin
									size_err_q  <= 1'b1;
									total_q     <= '0;
									head_q      <= NULL_LINK;
									out_valid_q <= 1'b1;
									rsp_q       <= '{ST_TOO_SMALL, '0, '0};
								end else begin
									aligned_q <= aligned_nxt;
									state_q   <= S_CNT_GO;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
								rsp_q       <= '{ST_OK, '0, '0};
							end
						endcase
					end
				end
				S_ALLOC_RD: begin
					head_q      <= fwd_q ? fwd_data_q : link_rd_q;
					out_valid_q <= 1'b1;
					rsp_q       <= '{ST_OK, BIDX_W'(head_q), OFS_W'(prod)};
					state_q     <= S_IDLE;
				end
				S_CNT_GO: begin
					state_q <= S_CNT_WAIT;
				end
				S_CNT_WAIT: begin
					if (div_res.done) begin
						size_err_q  <= 1'b0;
						total_q     <= count_sat;
						head_q      <= (count_sat == '0) ? NULL_LINK : '0;
						out_valid_q <= 1'b1;
						rsp_q       <= '{ST_OK, '0, '0};
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.block_index = rsp_q.block_index;
	assign rsp.byte_offset = rsp_q.byte_offset;

endmodule

FILE: tb/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps

module fixed_block_pool_allocator_tb;
	import fbpa_pkg::*;

	localparam int MAX_BLOCKS      = 1024;
	localparam int ALIGN_BYTES     = 16;
	localparam int MIN_BLOCK_BYTES = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int NUM_PHASES      = 10;
	localparam int PHASE_REQS      = 120;
	localparam int SETTLE_CYCLES   = 60;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	fbpa_req_if req_ch ();
	fbpa_rsp_if rsp_ch ();

	fixed_block_pool_allocator #(
		.MAX_BLOCKS     (MAX_BLOCKS),
		.ALIGN_BYTES    (ALIGN_BYTES),
		.MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// pool predictor state
	logic [POOL_W-1:0] cfg_pool_bytes;
	logic [BLK_W-1:0]  cfg_block_bytes;
	logic [10:0]       pool_link [MAX_BLOCKS];
	logic [10:0]       pool_head;
	logic [10:0]       pool_fresh;
	logic [10:0]       pool_total;
	logic [ALN_W-1:0]  pool_aligned;
	logic              pool_too_small;

	rsp_t              expected_rsps [$];
	int                held_blocks [$];
	int                error_count;
	bit                req_gaps_on;
	bit                rsp_stalls_on;
	int                rsp_hold_cycles;

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	function automatic void rebuild_pool();
		int req_bytes;
		int count;
		req_bytes = int'(cfg_block_bytes);
		pool_fresh = '0;
		if (req_bytes <= MIN_BLOCK_BYTES) begin
			pool_too_small = 1'b1;
			pool_total = '0;
			pool_head = 11'(MAX_BLOCKS);
			return;
		end
		pool_too_small = 1'b0;
		if (req_bytes % ALIGN_BYTES != 0)
			req_bytes += ALIGN_BYTES - req_bytes % ALIGN_BYTES;
		pool_aligned = ALN_W'(req_bytes);
		count = int'(cfg_pool_bytes) / req_bytes;
		if (count > MAX_BLOCKS)
			count = MAX_BLOCKS;
		pool_total = 11'(count);
		pool_head = (count == 0) ? 11'(MAX_BLOCKS) : 11'd0;
	endfunction

	function automatic rsp_t pool_answer(logic [ACT_W-1:0] act, logic [FIDX_W-1:0] idx);
		rsp_t r;
		logic [10:0] nxt;
		int got;
		int prod;
		r = '0;
		case (act)
			ACT_ALLOC: begin
				if (pool_too_small) begin
					r.status = ST_TOO_SMALL;
				end else begin
					if (pool_fresh < pool_total) begin
						nxt = pool_fresh + 11'd1;
						pool_link[pool_fresh] = (nxt < pool_total) ? nxt : 11'(MAX_BLOCKS);
						pool_fresh = nxt;
					end
					if (pool_head >= 11'(MAX_BLOCKS)) begin
						r.status = ST_EMPTY;
					end else begin
						got = int'(pool_head);
						pool_head = pool_link[got];
						prod = got * int'(pool_aligned);
						r.status = ST_OK;
						r.block_index = BIDX_W'(got);
						r.byte_offset = prod[OFS_W-1:0];
					end
				end
			end
			ACT_FREE: begin
				if (pool_too_small) begin
					r.status = ST_TOO_SMALL;
				end else if ({1'b0, idx} >= pool_total) begin
					r.status = ST_BAD_INDEX;
				end else begin
					pool_link[idx] = pool_head;
					pool_head = {1'b0, idx};
					r.status = ST_OK;
				end
			end
			ACT_REBUILD: begin
				rebuild_pool();
				r.status = pool_too_small ? ST_TOO_SMALL : ST_OK;
			end
			default: begin
				r.status = ST_OK;
			end
		endcase
		return r;
	endfunction

	task automatic send_req(input logic [ACT_W-1:0] act, input logic [FIDX_W-1:0] idx);
		int gap;
		rsp_t exp;
		gap = req_gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.free_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		exp = pool_answer(act, idx);
		expected_rsps.push_back(exp);
		if (act == ACT_ALLOC && exp.status == ST_OK)
			held_blocks.push_back(int'(exp.block_index));
		if (act == ACT_REBUILD)
			held_blocks.delete();
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_POOL_BYTES)
			cfg_pool_bytes = data[POOL_W-1:0];
		else
			cfg_block_bytes = data[BLK_W-1:0];
	endtask

	task automatic set_pool(input int pool_bytes, input int block_bytes);
		logic [CFG_W-1:0] blk_word;
		wait_idle();
		blk_word = {8'($urandom_range(0, 255)), 16'(block_bytes)};
		if ($urandom_range(0, 1)) begin
			write_reg(REG_POOL_BYTES, CFG_W'(pool_bytes));
			write_reg(REG_BLOCK_BYTES, blk_word);
		end else begin
			write_reg(REG_BLOCK_BYTES, blk_word);
			write_reg(REG_POOL_BYTES, CFG_W'(pool_bytes));
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	task automatic check_rsp();
		rsp_t exp;
		if (expected_rsps.size() == 0) begin
			$display("%0t: unexpected response, expected none actual status %0d index %0d offset %0d",
				$time, rsp_ch.status, rsp_ch.block_index, rsp_ch.byte_offset);
			error_count++;
		end else begin
			exp = expected_rsps.pop_front();
			check_field("status", 32'(exp.status), 32'(rsp_ch.status));
			check_field("block_index", 32'(exp.block_index), 32'(rsp_ch.block_index));
			check_field("byte_offset", 32'(exp.byte_offset), 32'(rsp_ch.byte_offset));
		end
	endtask

	initial begin
		int stall;
		rsp_ch.ready = 1'b1;
		forever begin
			@(posedge clk);
			stall = 0;
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_rsp();
				stall = rsp_stalls_on ? $urandom_range(0, 7) : 0;
			end
			if (rsp_hold_cycles > 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic test_reset_state();
		send_req(ACT_ALLOC, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, 10'd1);
		send_req(ACT_ALLOC, '0);
		// return a block that was never handed out
		send_req(ACT_FREE, 10'd700);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, 10'd1023);
		send_req(ACT_UNUSED, 10'd1023);
		send_req(ACT_ALLOC, '0);
	endtask

	task automatic test_size_limits();
		set_pool(65536, MIN_BLOCK_BYTES);
		send_req(ACT_REBUILD, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, '0);
		set_pool(40, MIN_BLOCK_BYTES + 1);
		send_req(ACT_REBUILD, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, 10'd2);
		send_req(ACT_FREE, 10'd0);
		send_req(ACT_ALLOC, '0);
		set_pool(16777215, 65535);
		send_req(ACT_REBUILD, '0);
		send_req(ACT_FREE, 10'd254);
		send_req(ACT_ALLOC, '0);
		send_req(ACT_FREE, 10'd255);
		set_pool(0, 16);
		send_req(ACT_REBUILD, '0);
		send_req(ACT_ALLOC, '0);
		set_pool(16777215, 1);
		send_req(ACT_REBUILD, '0);
		set_pool(16777215, 17);
		send_req(ACT_REBUILD, '0);
		send_req(ACT_FREE, 10'd1023);
		send_req(ACT_ALLOC, '0);
	endtask

	task automatic test_random_traffic();
		int blk;
		int pool;
		int pick;
		int k;
		logic [FIDX_W-1:0] idx;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case ($urandom_range(0, 6))
				0: begin
					blk = $urandom_range(1, MIN_BLOCK_BYTES);
					pool = $urandom_range(0, 16777215);
				end
				1: begin
					blk = $urandom_range(MIN_BLOCK_BYTES + 1, 65535);
					pool = $urandom_range(0, 16777215);
				end
				2: begin
					blk = 65521 + $urandom_range(0, 14);
					pool = $urandom_range(0, 16777215);
				end
				3: begin
					blk = ALIGN_BYTES;
					pool = 16777215;
				end
				default: begin
					blk = $urandom_range(MIN_BLOCK_BYTES + 1, 200);
					pool = $urandom_range(0, 40 * blk);
				end
			endcase
			set_pool(pool, blk);
			req_gaps_on = $urandom_range(0, 3) != 0;
			rsp_stalls_on = $urandom_range(0, 3) != 0;
			send_req(ACT_REBUILD, '0);
			for (int n = 0; n < PHASE_REQS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85 && pick >= 45 && held_blocks.size() != 0) begin
					k = $urandom_range(0, held_blocks.size() - 1);
					idx = FIDX_W'(held_blocks[k]);
					held_blocks.delete(k);
					send_req(ACT_FREE, idx);
				end else if (pick < 85) begin
					send_req(ACT_ALLOC, FIDX_W'($urandom_range(0, 1023)));
				end else if (pick < 92) begin
					if (pool_total != 0 && $urandom_range(0, 1))
						idx = FIDX_W'($urandom_range(0, int'(pool_total) - 1));
					else
						idx = FIDX_W'($urandom_range(0, 1023));
					send_req(ACT_FREE, idx);
				end else if (pick < 96) begin
					send_req(ACT_UNUSED, FIDX_W'($urandom_range(0, 1023)));
				end else if (pick < 98 && held_blocks.size() != 0) begin
					k = $urandom_range(0, held_blocks.size() - 1);
					send_req(ACT_FREE, FIDX_W'(held_blocks[k]));
				end else begin
					send_req(ACT_REBUILD, FIDX_W'($urandom_range(0, 1023)));
				end
			end
		end
		req_gaps_on = 1'b1;
		rsp_stalls_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		int k;
		set_pool(1024, ALIGN_BYTES);
		req_gaps_on = 1'b0;
		rsp_stalls_on = 1'b0;
		send_req(ACT_REBUILD, '0);
		// hold the response side while requests keep coming
		rsp_hold_cycles = 200;
		for (int n = 0; n < 40; n++) begin
			if (n % 3 == 2 && held_blocks.size() != 0) begin
				k = $urandom_range(0, held_blocks.size() - 1);
				send_req(ACT_FREE, FIDX_W'(held_blocks[k]));
				held_blocks.delete(k);
			end else begin
				send_req(ACT_ALLOC, '0);
			end
		end
		req_gaps_on = 1'b1;
		rsp_stalls_on = 1'b1;
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_POOL_BYTES;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ALLOC;
		req_ch.free_index = '0;
		error_count = 0;
		req_gaps_on = 1'b1;
		rsp_stalls_on = 1'b1;
		rsp_hold_cycles = 0;
		cfg_pool_bytes = POOL_W'(RST_POOL_BYTES);
		cfg_block_bytes = BLK_W'(RST_BLOCK_BYTES);
		pool_aligned = ALN_W'(RST_BLOCK_BYTES);
		rebuild_pool();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_size_limits();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hdl/fbpa_pkg.sv
hdl/fbpa_req_if.sv
hdl/fbpa_rsp_if.sv
hdl/fbpa_div.sv
hdl/fixed_block_pool_allocator.sv
tb/fixed_block_pool_allocator_tb.sv
